FILE: rtl/orqm_pkg.sv
// ----------------------------------------------------------------------------
// orqm_pkg: shared definitions for the overwrite ring queue with mean
// Operation codes carried on the op input and the fixed occupancy width.
// ----------------------------------------------------------------------------
package orqm_pkg;

  // op input codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // occupancy output width (queue depth is at most 127)
  localparam int OCC_BITS = 7;

endpackage

FILE: rtl/orqm_store.sv
// ----------------------------------------------------------------------------
// orqm_store: entry memory of the ring queue
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module orqm_store #(
  parameter int DEPTH      = 8,
  parameter int VALUE_BITS = 12,
  parameter int IDX_BITS   = 3
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_BITS-1:0]   wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic [IDX_BITS-1:0]   rd_addr,
  output logic [VALUE_BITS-1:0] rd_data
);

  logic [VALUE_BITS-1:0] entries [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= entries[rd_addr];
  end

endmodule

FILE: rtl/orqm_div.sv
// ----------------------------------------------------------------------------
// orqm_div: bit-serial rounded mean divider
// Computes (2*total + count) / (2*count) by restoring division, one
// quotient bit per cycle, MSB first. The quotient is known to fit in
// VALUE_BITS, so the upper dividend bits preload the partial remainder.
// ----------------------------------------------------------------------------
module orqm_div #(
  parameter int VALUE_BITS = 12,
  parameter int COUNT_BITS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [VALUE_BITS+COUNT_BITS-1:0] total,
  input  logic [COUNT_BITS-1:0]            count,
  output logic [VALUE_BITS-1:0]            quotient,
  output logic                             done
);

  localparam int TotalBits = VALUE_BITS + COUNT_BITS;
  localparam int StepBits  = $clog2(VALUE_BITS + 1);

  logic [TotalBits:0]    dividend;
  logic [COUNT_BITS:0]   divisor;
  logic [COUNT_BITS:0]   rem;
  logic [VALUE_BITS-1:0] shreg;
  logic [StepBits-1:0]   steps;
  logic                  busy;
  logic [COUNT_BITS+1:0] trial;
  logic                  fits;

  // dividend 2*total + count
  assign dividend = {total, 1'b0} + (TotalBits+1)'(count);

  // one restoring step: shift in the next dividend bit, try subtract
  assign trial = {rem, shreg[VALUE_BITS-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= StepBits'(VALUE_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == StepBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shreg holds the low dividend bits and collects quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= {count, 1'b0};
      rem     <= dividend[TotalBits:VALUE_BITS];
      shreg   <= dividend[VALUE_BITS-1:0];
    end else if (busy) begin
      if (fits) begin
        rem <= (COUNT_BITS+1)'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[COUNT_BITS:0];
      end
      shreg <= {shreg[VALUE_BITS-2:0], fits};
    end
  end

  assign quotient = shreg;

endmodule

FILE: rtl/overwrite_ring_queue_with_mean.sv
// ----------------------------------------------------------------------------
// overwrite_ring_queue_with_mean: ring queue that overwrites its oldest
// entry when full and reports the rounded mean of the stored values
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word: op and height_value.
//   op insert appends height_value (dropping the oldest entry when full) and
//   returns the mean rounded half up; op remove pops the oldest entry, or
//   returns empty_error when the queue holds nothing.
//   Output channel (out_valid/out_ready) returns one word per input word.
// Sequence:
//   One word is processed at a time; in_ready is high only while idle.
//   Insert: S_UPDATE, S_DIVLOAD, then S_DIVWAIT while the bit-serial
//   divider runs (one quotient bit per cycle), then S_DONE loads out_valid;
//   the next word is accepted only after the result is loaded.
//   Remove: S_UPDATE, then S_DONE loads out_valid.
// Reset:
//   rst empties the queue and clears the running sum; entry memory is not
//   cleared, as entries are only read after they are written.
// Stall:
//   A result sits in the output register until taken; the next word is
//   accepted meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module overwrite_ring_queue_with_mean #(
  parameter int QUEUE_DEPTH = 8,
  parameter int VALUE_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [VALUE_BITS-1:0]         height_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_BITS-1:0]         average_height,
  output logic [VALUE_BITS-1:0]         removed_height,
  output logic                          empty_error,
  output logic [orqm_pkg::OCC_BITS-1:0] occupancy
);

  localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TotalBits = VALUE_BITS + CountBits;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_UPDATE  = 5'b00010,
    S_DIVLOAD = 5'b00100,
    S_DIVWAIT = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state;

  logic                  op_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [IdxBits-1:0]    head;
  logic [IdxBits-1:0]    tail;
  logic [CountBits-1:0]  count;
  logic [TotalBits-1:0]  total;
  logic [VALUE_BITS-1:0] res_avg;
  logic [VALUE_BITS-1:0] res_removed;
  logic                  res_err;

  logic                  in_fire;
  logic                  full;
  logic [IdxBits-1:0]    head_inc;
  logic [IdxBits-1:0]    tail_inc;
  logic [VALUE_BITS-1:0] oldest;
  logic                  store_wr;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic                  out_load;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign full      = (count == CountBits'(QUEUE_DEPTH));
  assign head_inc  = (head == IdxBits'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == IdxBits'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign store_wr  = (state == S_UPDATE) && (op_q == orqm_pkg::OP_INSERT);
  assign div_start = (state == S_DIVLOAD);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // entry memory; head entry is read every cycle
  orqm_store #(
    .DEPTH      (QUEUE_DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .IDX_BITS   (IdxBits)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (tail),
    .wr_data (value_q),
    .rd_addr (head),
    .rd_data (oldest)
  );

  // serial mean divider
  orqm_div #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (CountBits)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .total    (total),
    .count    (count),
    .quotient (div_quot),
    .done     (div_done)
  );

  // sequencer and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      total <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (op_q == orqm_pkg::OP_INSERT) begin
            tail <= tail_inc;
            if (full) begin
              head  <= head_inc;
              total <= total - TotalBits'(oldest) + TotalBits'(value_q);
            end else begin
              count <= count + 1'b1;
              total <= total + TotalBits'(value_q);
            end
            state <= S_DIVLOAD;
          end else begin
            if (count != '0) begin
              head  <= head_inc;
              count <= count - 1'b1;
              total <= total - TotalBits'(oldest);
            end
            state <= S_DONE;
          end
        end
        S_DIVLOAD: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // captured word and pending result fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= op;
      value_q <= height_value;
    end
    if (state == S_UPDATE) begin
      res_avg     <= '0;
      res_removed <= '0;
      res_err     <= 1'b0;
      if (op_q == orqm_pkg::OP_REMOVE) begin
        if (count != '0) begin
          res_removed <= oldest;
        end else begin
          res_err <= 1'b1;
        end
      end
    end
    if ((state == S_DIVWAIT) && div_done) begin
      res_avg <= div_quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_height <= res_avg;
      removed_height <= res_removed;
      empty_error    <= res_err;
      occupancy      <= orqm_pkg::OCC_BITS'(count);
    end
  end

endmodule

FILE: rtl/orqm_checker.sv
// ----------------------------------------------------------------------------
// orqm_checker: port-level checks for the ring queue with mean
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module orqm_checker #(
  parameter int QUEUE_DEPTH = 8,
  parameter int VALUE_BITS  = 12
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [VALUE_BITS-1:0]         average_height,
  input logic [VALUE_BITS-1:0]         removed_height,
  input logic                          empty_error,
  input logic [orqm_pkg::OCC_BITS-1:0] occupancy
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(average_height) &&
      $stable(removed_height) && $stable(empty_error) && $stable(occupancy))
    else $error("result word changed while stalled");

  // one word in flight: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // an empty error leaves every other field at zero
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_error |-> average_height == '0 &&
      removed_height == '0 && occupancy == '0)
    else $error("empty error with nonzero fields");

  // occupancy bounded; a popped value comes with a zero mean and no error
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= orqm_pkg::OCC_BITS'(QUEUE_DEPTH) &&
      (removed_height == '0 || (average_height == '0 && !empty_error)))
    else $error("occupancy or remove result out of range");

endmodule

bind overwrite_ring_queue_with_mean orqm_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .VALUE_BITS  (VALUE_BITS)
) u_orqm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .average_height (average_height),
  .removed_height (removed_height),
  .empty_error    (empty_error),
  .occupancy      (occupancy)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: overwrite ring queue with mean
// Drives insert and remove words through the valid/ready input channel,
// keeps its own ring queue and running sum to predict each result word,
// and checks every returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------

localparam int QUEUE_SLOTS = 8;
localparam int HEIGHT_BITS = 12;
localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = {HEIGHT_BITS{1'b1}};

typedef struct packed {
  logic [HEIGHT_BITS-1:0]        average_height;
  logic [HEIGHT_BITS-1:0]        removed_height;
  logic                          empty_error;
  logic [orqm_pkg::OCC_BITS-1:0] occupancy;
} queue_result_t;

// Ring queue with running sum; one predicted result word per accepted word
class mean_queue_board;
  logic [HEIGHT_BITS-1:0] slots[QUEUE_SLOTS];
  int unsigned oldest_pos;
  int unsigned next_pos;
  int unsigned fill;
  int unsigned height_sum;
  queue_result_t awaited[$];
  int unsigned failures;
  int unsigned checked;
  int unsigned inserts;
  int unsigned removes;
  int unsigned overwrites;
  int unsigned underflows;

  function new();
    oldest_pos = 0;
    next_pos   = 0;
    fill       = 0;
    height_sum = 0;
    failures   = 0;
    checked    = 0;
    inserts    = 0;
    removes    = 0;
    overwrites = 0;
    underflows = 0;
  endfunction

  function logic [HEIGHT_BITS-1:0] pop_oldest();
    logic [HEIGHT_BITS-1:0] v;
    v = slots[oldest_pos];
    oldest_pos = (oldest_pos + 1) % QUEUE_SLOTS;
    fill--;
    height_sum -= v;
    return v;
  endfunction

  // accepted input word: update the queue and queue up the expected result
  function void note_word(logic op_code, logic [HEIGHT_BITS-1:0] height);
    queue_result_t r;
    r = '0;
    if (op_code == orqm_pkg::OP_INSERT) begin
      inserts++;
      // full: the oldest entry is dropped before the append
      if (fill == QUEUE_SLOTS) begin
        overwrites++;
        void'(pop_oldest());
      end
      slots[next_pos] = height;
      next_pos = (next_pos + 1) % QUEUE_SLOTS;
      fill++;
      height_sum += height;
      // mean rounded half up
      r.average_height = HEIGHT_BITS'((2 * height_sum + fill) / (2 * fill));
    end else begin
      removes++;
      if (fill > 0) begin
        r.removed_height = pop_oldest();
      end else begin
        r.empty_error = 1'b1;
        underflows++;
      end
    end
    r.occupancy = orqm_pkg::OCC_BITS'(fill);
    awaited.push_back(r);
  endfunction

  // accepted result word: compare with the oldest expectation
  function void check_word(queue_result_t got);
    queue_result_t want;
    bit bad;
    checked++;
    if (awaited.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result word with nothing expected: avg=%0d rem=%0d err=%0d occ=%0d",
                 got.average_height, got.removed_height, got.empty_error, got.occupancy);
      return;
    end
    want = awaited.pop_front();
    bad = (got.average_height !== want.average_height) ||
          (got.removed_height !== want.removed_height) ||
          (got.empty_error    !== want.empty_error)    ||
          (got.occupancy      !== want.occupancy);
    if (bad) begin
      failures++;
      if (failures <= 10)
        $display({"ERROR: word %0d exp avg=%0d rem=%0d err=%0d occ=%0d, ",
                  "got avg=%0d rem=%0d err=%0d occ=%0d"},
                 checked, want.average_height, want.removed_height, want.empty_error,
                 want.occupancy, got.average_height, got.removed_height, got.empty_error,
                 got.occupancy);
    end
  endfunction

  // anything still expected at the end is a failure
  function void close_out();
    if (awaited.size() != 0) begin
      failures += awaited.size();
      $display("ERROR: %0d result words never arrived", awaited.size());
    end
  endfunction
endclass

module testbench;

  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 25;
  localparam int PHASE_WORDS = 150;
  localparam int PHASES      = 10;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          op = orqm_pkg::OP_INSERT;
  logic [HEIGHT_BITS-1:0]        height_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [HEIGHT_BITS-1:0]        average_height;
  logic [HEIGHT_BITS-1:0]        removed_height;
  logic                          empty_error;
  logic [orqm_pkg::OCC_BITS-1:0] occupancy;

  mean_queue_board board;
  int unsigned     burst_left = 0;
  int unsigned     stuck = 0;
  rx_mode_t        rx_mode = RX_OPEN;
  int unsigned     rx_mode_left = 0;
  int unsigned     rx_tick = 0;

  overwrite_ring_queue_with_mean #(
    .QUEUE_DEPTH(QUEUE_SLOTS),
    .VALUE_BITS (HEIGHT_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .height_value  (height_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .average_height(average_height),
    .removed_height(removed_height),
    .empty_error   (empty_error),
    .occupancy     (occupancy)
  );

  always #6 clk = ~clk;

  // Send one word; bursts of random length with random gaps in between
  task automatic send_word(input logic op_code, input logic [HEIGHT_BITS-1:0] height);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    op           <= op_code;
    height_value <= height;
    do @(posedge clk); while (!in_ready);
    board.note_word(op_code, height);
  endtask

  // Hold off the sender until every expected word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.awaited.size() != 0);
  endtask

  function automatic logic [HEIGHT_BITS-1:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return HEIGHT_MAX;
      default: return HEIGHT_BITS'($urandom_range(0, HEIGHT_MAX));
    endcase
  endfunction

  // Receiver: changes between always ready, coin flips and a fixed stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 2));
        rx_mode_left <= $urandom_range(50, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= ($urandom_range(0, 99) < 60);
        RX_PATTERN: out_ready <= ((rx_tick % 23) >= 9);
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_word(queue_result_t'{average_height, removed_height, empty_error, occupancy});
  end

  // Watchdog: ends the run when no handshake happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck == STUCK_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", STUCK_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned insert_pct;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty removes, rounding, fill, overwrite with wrap, drain to empty
    send_word(orqm_pkg::OP_REMOVE, HEIGHT_MAX);
    send_word(orqm_pkg::OP_REMOVE, '0);
    send_word(orqm_pkg::OP_INSERT, '0);
    send_word(orqm_pkg::OP_REMOVE, '0);
    send_word(orqm_pkg::OP_INSERT, 12'd1);
    send_word(orqm_pkg::OP_INSERT, 12'd2);          // mean 1.5 rounds up
    repeat (8) send_word(orqm_pkg::OP_INSERT, HEIGHT_MAX);
    send_word(orqm_pkg::OP_INSERT, 12'hAAA);
    send_word(orqm_pkg::OP_INSERT, 12'h555);
    repeat (9) send_word(orqm_pkg::OP_REMOVE, 12'hFFF);
    drain_results();

    // random: phases leaning toward inserts, removes, or balanced
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       insert_pct = 80;
        1:       insert_pct = 25;
        default: insert_pct = 55;
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < insert_pct)
          send_word(orqm_pkg::OP_INSERT, pick_height());
        else
          send_word(orqm_pkg::OP_REMOVE, HEIGHT_BITS'($urandom_range(0, HEIGHT_MAX)));
      end
      if (ph % 2 == 0)
        drain_results();
    end

    // wait for the last results, then a few more cycles for stray words
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    board.close_out();

    $display("Covered %0d inserts (%0d overwriting the oldest) and %0d removes (%0d on empty)",
             board.inserts, board.overwrites, board.removes, board.underflows);
    $display("Checked %0d result words, %0d failures", board.checked, board.failures);
    if (board.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
